### rtl/rgsp_pkg.sv
// shared types, register codes and alpha table function for the radial gradient sprite
`timescale 1ns / 1ps
`default_nettype none
package rgsp_pkg;

    // register codes on the configuration port
    typedef enum logic [7:0] {
        REG_SIZE  = 8'd0,
        REG_RED   = 8'd1,
        REG_GREEN = 8'd2,
        REG_BLUE  = 8'd3
    } cfg_reg_t;

    localparam logic [7:0] SIZE_RESET  = 8'd16;
    localparam logic [7:0] LEVEL_RESET = 8'd255;

    // control that travels with each pixel down the pipe
    typedef struct packed {
        logic        valid;
        logic        in_circle;
        logic        zero_rad;
        logic [15:0] index;
    } ctrl_t;

    // largest a in 0..255 with a^5 * 2^(9*frac) <= 255^5 * f^9
    function automatic logic [7:0] alpha_calc(input int f, input int frac);
        logic [199:0] rhs;
        logic [199:0] lhs;
        int lo;
        int hi;
        int mid;
        int k;
        rhs = 200'd1;
        for (k = 0; k < 5; k++)
            rhs = rhs * 200'd255;
        for (k = 0; k < 9; k++)
            rhs = rhs * 200'(f);
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = 200'd1;
            for (k = 0; k < 5; k++)
                lhs = lhs * 200'(mid);
            lhs = lhs << (9 * frac);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 8'(lo);
    endfunction

endpackage
`default_nettype wire

### rtl/rgsp_front.sv
// input capture, centre offsets, squared distance and linear index
`timescale 1ns / 1ps
`default_nettype none
module rgsp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    column,
    input  wire logic [7:0]    row,
    input  wire logic [7:0]    size,
    output rgsp_pkg::ctrl_t    ctrl,
    output logic      [18:0]   dist_sq,
    output logic      [15:0]   rad_sq
);
    import rgsp_pkg::*;

    logic              valid_a_reg;
    logic [7:0]        col_reg;
    logic [7:0]        row_reg;
    ctrl_t             ctrl_reg;
    ctrl_t             ctrl_next;
    logic [18:0]       dist_sq_reg;
    logic [18:0]       dist_sq_next;
    logic [15:0]       rad_sq_reg;
    logic [15:0]       rad_sq_next;

    logic [7:0]        size_eff;
    logic [7:0]        rad;
    logic signed [9:0] dx;
    logic signed [9:0] dy;
    logic signed [19:0] sqx;
    logic signed [19:0] sqy;

    always_comb
    begin
        size_eff     = (size == 8'd0) ? 8'd1 : size;
        rad          = size_eff - 8'd1;
        dx           = $signed({1'b0, col_reg, 1'b0}) - $signed({2'b00, rad});
        dy           = $signed({1'b0, row_reg, 1'b0}) - $signed({2'b00, rad});
        sqx          = dx * dx;
        sqy          = dy * dy;
        dist_sq_next = 19'(sqx[17:0]) + 19'(sqy[17:0]);
        rad_sq_next  = rad * rad;
        ctrl_next.valid     = valid_a_reg;
        ctrl_next.in_circle = dist_sq_next <= 19'(rad_sq_next);
        ctrl_next.zero_rad  = rad == 8'd0;
        ctrl_next.index     = ({8'd0, row_reg} * {8'd0, size_eff}) + 16'(col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            ctrl_reg    <= '0;
        end
        else
        begin
            valid_a_reg <= accept;
            ctrl_reg    <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        dist_sq_reg <= dist_sq_next;
        rad_sq_reg  <= rad_sq_next;
    end

    assign ctrl    = ctrl_reg;
    assign dist_sq = dist_sq_reg;
    assign rad_sq  = rad_sq_reg;
endmodule
`default_nettype wire

### rtl/rgsp_sqrt_stage.sv
// one bit of the scaled root search: largest q with (q*rad)^2 <= dist_sq << 2F
`timescale 1ns / 1ps
`default_nettype none
module rgsp_sqrt_stage #(
    parameter int FRAC_BITS = 10,
    parameter int BIT       = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rgsp_pkg::ctrl_t         ctrl_in,
    input  wire logic [2*FRAC_BITS+19:0] x_in,
    input  wire logic [15:0]             r2_in,
    input  wire logic [2*FRAC_BITS+19:0] p2_in,
    input  wire logic [2*FRAC_BITS+19:0] qr2_in,
    input  wire logic [FRAC_BITS:0]      q_in,
    output rgsp_pkg::ctrl_t              ctrl_out,
    output logic      [2*FRAC_BITS+19:0] x_out,
    output logic      [15:0]             r2_out,
    output logic      [2*FRAC_BITS+19:0] p2_out,
    output logic      [2*FRAC_BITS+19:0] qr2_out,
    output logic      [FRAC_BITS:0]      q_out
);
    import rgsp_pkg::*;

    localparam int XW = 2 * FRAC_BITS + 20;

    logic [XW-1:0]      r2_ext;
    logic [XW-1:0]      cand;
    logic               take;
    ctrl_t              ctrl_reg;
    logic [XW-1:0]      x_reg;
    logic [15:0]        r2_reg;
    logic [XW-1:0]      p2_reg;
    logic [XW-1:0]      p2_next;
    logic [XW-1:0]      qr2_reg;
    logic [XW-1:0]      qr2_next;
    logic [FRAC_BITS:0] q_reg;
    logic [FRAC_BITS:0] q_next;

    // (q + 2^b)^2 r^2 = p2 + 2 q r^2 2^b + r^2 4^b
    always_comb
    begin
        r2_ext   = XW'(r2_in);
        cand     = p2_in + (qr2_in << (BIT + 1)) + (r2_ext << (2 * BIT));
        take     = cand <= x_in;
        p2_next  = take ? cand : p2_in;
        qr2_next = take ? qr2_in + (r2_ext << BIT) : qr2_in;
        q_next   = q_in | ((FRAC_BITS + 1)'(take) << BIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_in;
        r2_reg  <= r2_in;
        p2_reg  <= p2_next;
        qr2_reg <= qr2_next;
        q_reg   <= q_next;
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign r2_out   = r2_reg;
    assign p2_out   = p2_reg;
    assign qr2_out  = qr2_reg;
    assign q_out    = q_reg;
endmodule
`default_nettype wire

### rtl/rgsp_alpha_rom.sv
// alpha falloff table, f^1.8 scaled to 255, with registered read
`timescale 1ns / 1ps
`default_nettype none
module rgsp_alpha_rom #(
    parameter int FRAC_BITS = 10
) (
    input  wire logic               clk,
    input  wire logic [FRAC_BITS:0] addr,
    output logic      [7:0]         data
);
    import rgsp_pkg::*;

    localparam int DEPTH = (1 << FRAC_BITS) + 1;

    logic [7:0] rom_w [DEPTH];
    logic [7:0] data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        assign rom_w[g] = alpha_calc(g, FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;
endmodule
`default_nettype wire

### rtl/radial_gradient_sprite_pixel.sv
// top level: radial gradient sprite pixel generator with configuration registers
// path: a started pixel passes the capture, front, root stage, table and output registers in that order
// throughput: one pixel per clock; busy stays low, the pipe never holds off a start
// the depth is set by the root search, one result bit per stage (FRAC_BITS+1 stages)
// reset: asynchronous, active low; clears the pipe valid bits, size 16, levels 255
// results cannot be stalled: each strobe lasts one cycle
`timescale 1ns / 1ps
`default_nettype none
module radial_gradient_sprite_pixel #(
    parameter int FRAC_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  column,
    input  wire logic [7:0]  row,
    output logic             result_valid,
    output logic      [31:0] pixel_word,
    output logic      [15:0] pixel_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import rgsp_pkg::*;

    localparam int XW      = 2 * FRAC_BITS + 20;
    localparam int NSTAGE  = FRAC_BITS + 1;
    localparam int LATENCY = FRAC_BITS + 5;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // configuration registers
    logic [7:0] size_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       accept;

    // no back pressure anywhere in the pipe
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            red_reg   <= LEVEL_RESET;
            green_reg <= LEVEL_RESET;
            blue_reg  <= LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // unknown register codes are dropped
            unique case (cfg_index)
                REG_SIZE:  size_reg  <= cfg_data;
                REG_RED:   red_reg   <= cfg_data;
                REG_GREEN: green_reg <= cfg_data;
                REG_BLUE:  blue_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // front: capture, offsets from centre in doubled coordinates, squares
    ctrl_t       front_ctrl;
    logic [18:0] dist_sq;
    logic [15:0] rad_sq;

    rgsp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .column  (column),
        .row     (row),
        .size    (size_reg),
        .ctrl    (front_ctrl),
        .dist_sq (dist_sq),
        .rad_sq  (rad_sq)
    );

    // root search chain, most significant bit first
    ctrl_t              ctrl_s [NSTAGE+1];
    logic [XW-1:0]      x_s    [NSTAGE+1];
    logic [15:0]        r2_s   [NSTAGE+1];
    logic [XW-1:0]      p2_s   [NSTAGE+1];
    logic [XW-1:0]      qr2_s  [NSTAGE+1];
    logic [FRAC_BITS:0] q_s    [NSTAGE+1];

    assign ctrl_s[0] = front_ctrl;
    assign x_s[0]    = XW'(dist_sq) << (2 * FRAC_BITS);
    assign r2_s[0]   = rad_sq;
    assign p2_s[0]   = '0;
    assign qr2_s[0]  = '0;
    assign q_s[0]    = '0;

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_sqrt
        rgsp_sqrt_stage #(
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[i]),
            .x_in     (x_s[i]),
            .r2_in    (r2_s[i]),
            .p2_in    (p2_s[i]),
            .qr2_in   (qr2_s[i]),
            .q_in     (q_s[i]),
            .ctrl_out (ctrl_s[i+1]),
            .x_out    (x_s[i+1]),
            .r2_out   (r2_s[i+1]),
            .p2_out   (p2_s[i+1]),
            .qr2_out  (qr2_s[i+1]),
            .q_out    (q_s[i+1])
        );
    end

    // factor = one - q; a zero radius (size zero or one) means full factor
    ctrl_t              q_ctrl;
    logic [FRAC_BITS:0] q_fin;
    logic [FRAC_BITS:0] factor;
    logic [7:0]         alpha;

    always_comb
    begin
        q_ctrl = ctrl_s[NSTAGE];
        if (q_ctrl.zero_rad)
            q_fin = '0;
        else if (q_s[NSTAGE] > ONE)
            q_fin = ONE;
        else
            q_fin = q_s[NSTAGE];
        factor = ONE - q_fin;
    end

    rgsp_alpha_rom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (factor),
        .data (alpha)
    );

    // control alongside the table read
    ctrl_t       rom_ctrl_reg;
    logic        out_valid_reg;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [15:0] index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_ctrl_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rom_ctrl_reg  <= q_ctrl;
            out_valid_reg <= rom_ctrl_reg.valid;
        end
    end

    // outside the circle the word is all zero
    assign word_next = rom_ctrl_reg.in_circle ? {red_reg, green_reg, blue_reg, alpha} : '0;

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        index_reg <= rom_ctrl_reg.index;
    end

    assign result_valid = out_valid_reg;
    assign pixel_word   = word_reg;
    assign pixel_index  = index_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LATENCY))
        else $error("result strobe without matching start");
    a_start_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("started pixel lost in pipe");
    a_color: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && pixel_word != 32'd0 && pixel_word[7:0] != 8'd0) |->
        (pixel_word[31:8] == {red_reg, green_reg, blue_reg}))
        else $error("color channels do not match registers");
`endif
endmodule
`default_nettype wire
